FILE: rtl/rgbs_pkg.sv
// Shared types and constants for the running Gaussian background subtractor.
`timescale 1ns / 1ps
package rgbs_pkg;

  localparam logic [15:0] WARM_RATE     = 16'd3277;
  localparam logic [31:0] SEED_VARIANCE = 32'd65536;
  localparam logic [8:0]  FRAMES_MAX    = 9'd511;
  localparam logic [16:0] TALLY_MAX     = 17'd131071;
  localparam int          CFG_W         = 18;

  typedef enum logic [1:0] {
    CFG_ALPHA     = 2'd0,
    CFG_K_SQUARED = 2'd1,
    CFG_WARMUP    = 2'd2,
    CFG_THRESHOLD = 2'd3
  } cfg_index_t;

  // Per-beat control that travels down the pipeline with each pixel
  typedef struct packed {
    logic        valid;
    logic        seed;
    logic        decided;
    logic        last;
    logic [15:0] rate;
  } ctl_t;

endpackage

FILE: rtl/running_gaussian_background_subtract.sv
// Top level: running Gaussian background subtractor on an RGB pixel stream.
`timescale 1ns / 1ps
// Accepts one pixel per clock and returns one result per pixel, in order.
// Per-pixel means live in one memory and the shared variance in another; each
// is read into a register in the stage before the one that needs it and
// written back from the stage that updates it, with the value of the preceding
// pixel forwarded when it updates the same entry (frames of one pixel). A stall
// on the result channel holds the whole pipeline, so throughput is one pixel
// per clock while results are taken. Memory contents are undefined after
// reset; the first frame seeds them and no clearing pass runs.
module running_gaussian_background_subtract
  import rgbs_pkg::*;
#(
  parameter int MAX_PIXELS = 65536
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_red,
  input  logic [7:0]        in_green,
  input  logic [7:0]        in_blue,
  input  logic              in_end_of_frame,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_is_foreground,
  output logic              out_decided,
  output logic              out_frame_done,
  output logic              out_motion_detected,
  output logic [16:0]       out_foreground_pixels,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam logic [AW-1:0] LAST_POS = AW'(MAX_PIXELS - 1);

  // configuration
  logic [15:0] alpha_r, k_squared_r;
  logic [7:0]  warmup_r;
  logic [17:0] threshold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r     <= 16'd655;
      k_squared_r <= 16'd2304;
      warmup_r    <= 8'd30;
      threshold_r <= 18'd19661;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_ALPHA:     alpha_r     <= cfg_data[15:0];
        CFG_K_SQUARED: k_squared_r <= cfg_data[15:0];
        CFG_WARMUP:    warmup_r    <= cfg_data[7:0];
        CFG_THRESHOLD: threshold_r <= cfg_data[17:0];
        default:       alpha_r     <= alpha_r;
      endcase
    end
  end

  // pipeline enable: everything advances unless a result waits untaken
  logic en;
  logic out_valid_r;
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  logic accept;
  assign accept = in_valid && en;

  // frame control at acceptance
  logic [AW-1:0] pos_r;
  logic [8:0]    frames_r;
  ctl_t          ctl0;

  always_comb begin
    ctl0.valid   = accept;
    ctl0.seed    = (frames_r == 9'd0);
    ctl0.decided = {1'b0, frames_r} > ({2'b00, warmup_r} + 10'd1);
    ctl0.last    = in_end_of_frame;
    ctl0.rate    = (frames_r <= {1'b0, warmup_r}) ? WARM_RATE : alpha_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      frames_r <= '0;
    end else if (accept) begin
      if (in_end_of_frame) begin
        pos_r <= '0;
        if (frames_r < FRAMES_MAX) frames_r <= frames_r + 9'd1;
      end else begin
        pos_r <= (pos_r == LAST_POS) ? '0 : pos_r + AW'(1);
      end
    end
  end

  // memories
  logic [47:0] mean_mem [MAX_PIXELS];
  logic [31:0] var_mem  [MAX_PIXELS];
  logic [47:0] mean_rd_r;
  logic [31:0] var_rd_r;

  // stage registers
  ctl_t ctl1_r, ctl2_r, ctl3_r, ctl4_r, ctl5_r, ctl6_r;
  logic [AW-1:0] addr1_r, addr2_r, addr3_r, addr4_r, addr5_r;
  logic [23:0] px1_r, px2_r;
  logic [47:0] m2_r;
  logic [31:0] sq3_r [3];
  logic [31:0] d2_4_r, d2_5_r, var5_r;
  logic        fg6_r;

  // stage 1: mean blend
  logic [47:0] mean_old, m1_nxt;
  logic [16:0] inv1;
  always_comb begin
    logic [15:0] tgt, old;
    logic [33:0] acc;
    mean_old = (ctl2_r.valid && addr2_r == addr1_r) ? m2_r : mean_rd_r;
    inv1     = 17'd65536 - {1'b0, ctl1_r.rate};
    m1_nxt   = '0;
    for (int c = 0; c < 3; c++) begin
      tgt = {px1_r[c*8 +: 8], 8'd0};
      old = mean_old[c*16 +: 16];
      acc = 34'(ctl1_r.rate * tgt) + 34'(inv1 * old) + 34'd32768;
      m1_nxt[c*16 +: 16] = ctl1_r.seed ? tgt : acc[31:16];
    end
  end

  // stage 2: squared deviation per channel
  logic [31:0] sq2_nxt [3];
  always_comb begin
    logic [15:0] tgt, m, diff;
    for (int c = 0; c < 3; c++) begin
      tgt  = {px2_r[c*8 +: 8], 8'd0};
      m    = m2_r[c*16 +: 16];
      diff = (m >= tgt) ? m - tgt : tgt - m;
      sq2_nxt[c] = diff * diff;
    end
  end

  // stage 3: sum to Q18.14
  logic [33:0] sum3;
  assign sum3 = 34'(sq3_r[0]) + 34'(sq3_r[1]) + 34'(sq3_r[2]);

  // stage 4: variance blend
  logic [31:0] var_old, var4_nxt;
  logic [16:0] inv4;
  logic [49:0] vacc;
  always_comb begin
    var_old  = (ctl5_r.valid && addr5_r == addr4_r) ? var5_r : var_rd_r;
    inv4     = 17'd65536 - {1'b0, ctl4_r.rate};
    vacc     = 50'(ctl4_r.rate * d2_4_r) + 50'(inv4 * var_old) + 50'd32768;
    var4_nxt = ctl4_r.seed ? SEED_VARIANCE : vacc[47:16];
  end

  // stage 5: foreground test
  logic [47:0] kvar;
  logic        fg5_nxt;
  assign kvar    = k_squared_r * var5_r;
  assign fg5_nxt = ctl5_r.decided && ({8'd0, d2_5_r, 8'd0} > kvar);

  always_ff @(posedge clk) begin
    if (en) begin
      mean_rd_r <= mean_mem[pos_r];
      var_rd_r  <= var_mem[addr3_r];
      if (ctl1_r.valid) mean_mem[addr1_r] <= m1_nxt;
      if (ctl4_r.valid) var_mem[addr4_r]  <= var4_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
      ctl4_r <= '0;
      ctl5_r <= '0;
      ctl6_r <= '0;
    end else if (en) begin
      ctl1_r <= ctl0;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
      ctl4_r <= ctl3_r;
      ctl5_r <= ctl4_r;
      ctl6_r <= ctl5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      addr1_r <= pos_r;
      px1_r   <= {in_blue, in_green, in_red};
      addr2_r <= addr1_r;
      px2_r   <= px1_r;
      m2_r    <= m1_nxt;
      addr3_r <= addr2_r;
      for (int c = 0; c < 3; c++) sq3_r[c] <= sq2_nxt[c];
      addr4_r <= addr3_r;
      d2_4_r  <= sum3[33:2];
      addr5_r <= addr4_r;
      d2_5_r  <= d2_4_r;
      var5_r  <= var4_nxt;
      fg6_r   <= fg5_nxt;
    end
  end

  // stage 6: frame tally and result register
  logic [16:0] tally_r, tally_new;
  logic [18:0] tally_x3;
  assign tally_new = (fg6_r && tally_r < TALLY_MAX) ? tally_r + 17'd1 : tally_r;
  assign tally_x3  = 19'(tally_new) + {tally_new, 1'b0};

  logic fg_r, decided_r, done_r, motion_r;
  logic [16:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      tally_r     <= '0;
    end else if (en) begin
      out_valid_r <= ctl6_r.valid;
      if (ctl6_r.valid) tally_r <= ctl6_r.last ? 17'd0 : tally_new;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fg_r      <= fg6_r;
      decided_r <= ctl6_r.decided;
      done_r    <= ctl6_r.last;
      motion_r  <= ctl6_r.last && ctl6_r.decided && (tally_x3 > {1'b0, threshold_r});
      count_r   <= tally_new;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_is_foreground     = fg_r;
  assign out_decided           = decided_r;
  assign out_frame_done        = done_r;
  assign out_motion_detected   = motion_r;
  assign out_foreground_pixels = count_r;

endmodule
